[sv/mvrm_pkg.sv]
// types and constants shared by the voice mixer top level and its checker
// no dependencies
`default_nettype none

package mvrm_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_MIX   = 2'd3
  } func_e;

  typedef struct packed {
    func_e       func;
    logic [3:0]  voice;
    logic [15:0] address;
    logic [7:0]  data_byte;
    logic [15:0] sample_count;
    logic [15:0] loop_start;
    logic        looping;
    logic [15:0] step;
    logic        sixteen_bit;
    logic [8:0]  left_volume;
    logic [8:0]  right_volume;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
  } out_item_t;

  localparam int unsigned MIX_SHIFT    = 20;
  localparam int          SAT_HIGH     = 32767;
  localparam int          SAT_LOW      = -32768;
  localparam logic [8:0]  MASTER_RESET = 9'd179;

endpackage

`default_nettype wire

[sv/multi_voice_resampling_mixer.sv]
// Stereo wavetable mixer. An item loads one sample byte, starts or stops a voice,
// or mixes one frame. Start and stop are handled without leaving the idle state. A
// load passes the address through the address reducer, a mask when SAMPLE_BYTES is a
// power of two and otherwise bit-serial. A mix visits the voices one after another:
// an idle or silent voice is only checked, a playing voice has its address reduced
// and its sample read, a 16-bit voice reads a second byte, a loop wrap adds the wrap
// state, and the frame closes with master gain and saturation. All products go through
// one shared multiplier and every sample byte through the single read port of the
// sample memory. A finished frame waits in an output register, so the next item may
// be taken while it is still pending.
// depends on mvrm_pkg and mvrm_addr_mod
`default_nettype none

module multi_voice_resampling_mixer #(
  parameter int unsigned VOICES        = 16,
  parameter int unsigned SAMPLE_BYTES  = 65536,
  parameter int unsigned FRACTION_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mvrm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mvrm_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [8:0]          cfg_wdata_i
);

  import mvrm_pkg::*;

  localparam int unsigned IDX_W = 32 - FRACTION_BITS;
  localparam int unsigned SUM_W = IDX_W + 2;
  localparam int unsigned AW    = $clog2(SAMPLE_BYTES);
  localparam int unsigned VIW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned ACC_W = 25 + $clog2(VOICES);
  localparam int unsigned P_W   = ACC_W + 10;

  localparam logic signed [P_W-1:0] SAT_HI = P_W'(SAT_HIGH);
  localparam logic signed [P_W-1:0] SAT_LO = P_W'(SAT_LOW);

  typedef enum logic [14:0] {
    ST_IDLE  = 15'b000000000000001,
    ST_LDW   = 15'b000000000000010,
    ST_CHECK = 15'b000000000000100,
    ST_WRAP  = 15'b000000000001000,
    ST_ADDR  = 15'b000000000010000,
    ST_MOD   = 15'b000000000100000,
    ST_RD1   = 15'b000000001000000,
    ST_RD2   = 15'b000000010000000,
    ST_MULL  = 15'b000000100000000,
    ST_MULR  = 15'b000001000000000,
    ST_ACCR  = 15'b000010000000000,
    ST_FINL  = 15'b000100000000000,
    ST_FINR  = 15'b001000000000000,
    ST_SATR  = 15'b010000000000000,
    ST_DONE  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  // per-voice registers, read only at the current voice index
  logic [VOICES-1:0] active_q;
  logic [31:0]       pos_arr_q   [VOICES];
  logic [15:0]       base_arr_q  [VOICES];
  logic [15:0]       len_arr_q   [VOICES];
  logic [15:0]       lpt_arr_q   [VOICES];
  logic              loop_arr_q  [VOICES];
  logic [15:0]       inc_arr_q   [VOICES];
  logic              wide_arr_q  [VOICES];
  logic [8:0]        gl_arr_q    [VOICES];
  logic [8:0]        gr_arr_q    [VOICES];

  logic [7:0] mem [SAMPLE_BYTES];
  logic [7:0] rdata_q;
  logic [AW-1:0] raddr;
  logic          mem_we;

  logic [8:0]     master_q;
  in_item_t       req_q;
  logic [VIW-1:0] k_q;
  logic [31:0]    pos_q;
  logic [AW-1:0]  addr_q;
  logic [7:0]     lo_q;
  logic signed [15:0]      sample_q;
  logic signed [ACC_W-1:0] acc_l_q, acc_r_q;
  logic signed [P_W-1:0]   prod_q;
  logic signed [15:0]      res_l_q, res_r_q;
  logic      out_valid_q;
  out_item_t out_q;

  logic in_acc;
  logic voice_ok;
  logic [VIW-1:0] wr_idx;
  logic last_voice;
  logic [31:0] len_fix;
  logic [31:0] pos_cur;
  logic [IDX_W-1:0] idx;
  logic [SUM_W-1:0] addr_sum;
  logic [AW:0] addr_inc;
  logic [AW-1:0] addr_next;

  logic             mod_start;
  logic [SUM_W-1:0] mod_dividend;
  logic             mod_done;
  logic [AW-1:0]    mod_rem;

  logic signed [ACC_W-1:0] mul_a;
  logic signed [9:0]       mul_b;
  logic signed [P_W-1:0]   mul_p;
  logic out_load;

  function automatic logic signed [15:0] sat16(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] s;
    s = p >>> MIX_SHIFT;
    if (s > SAT_HI) begin
      return 16'sh7fff;
    end else if (s < SAT_LO) begin
      return 16'sh8000;
    end
    return 16'(s);
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign voice_ok   = 32'(in_data_i.voice) < VOICES;
  assign wr_idx     = VIW'(in_data_i.voice);
  assign last_voice = (k_q == VIW'(VOICES - 1));

  assign len_fix  = 32'({len_arr_q[k_q], {FRACTION_BITS{1'b0}}});
  assign pos_cur  = pos_arr_q[k_q];
  assign idx      = pos_q[31:FRACTION_BITS];
  assign addr_sum = SUM_W'(base_arr_q[k_q])
                  + (wide_arr_q[k_q] ? {1'b0, idx, 1'b0} : SUM_W'(idx));
  // second byte of a 16-bit sample, wrapped at the memory size
  assign addr_inc  = {1'b0, addr_q} + (AW + 1)'(1);
  assign addr_next = (addr_inc == (AW + 1)'(SAMPLE_BYTES)) ? '0 : AW'(addr_inc);

  assign mod_start    = (in_acc && in_data_i.func == FUNC_LOAD) || (state_q == ST_ADDR);
  assign mod_dividend = (state_q == ST_IDLE) ? SUM_W'(in_data_i.address) : addr_sum;

  mvrm_addr_mod #(
    .DIVIDEND_W (SUM_W),
    .MODULUS    (SAMPLE_BYTES),
    .RES_W      (AW)
  ) u_addr_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dividend),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // sample memory, one write and one registered read port
  assign mem_we = (state_q == ST_LDW) && mod_done;
  assign raddr  = (state_q == ST_MOD) ? mod_rem : addr_next;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mod_rem] <= req_q.data_byte;
    end
    rdata_q <= mem[raddr];
  end

  // shared multiplier
  always_comb begin
    case (state_q)
      ST_MULR: begin
        mul_a = {{(ACC_W - 16){sample_q[15]}}, sample_q};
        mul_b = $signed({1'b0, gr_arr_q[k_q]});
      end
      ST_FINL: begin
        mul_a = acc_l_q;
        mul_b = $signed({1'b0, master_q});
      end
      ST_FINR: begin
        mul_a = acc_r_q;
        mul_b = $signed({1'b0, master_q});
      end
      default: begin
        mul_a = {{(ACC_W - 16){sample_q[15]}}, sample_q};
        mul_b = $signed({1'b0, gl_arr_q[k_q]});
      end
    endcase
  end

  assign mul_p = P_W'(mul_a) * P_W'(mul_b);

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.func == FUNC_LOAD) begin
            state_d = ST_LDW;
          end else if (in_data_i.func == FUNC_MIX) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_LDW: begin
        if (mod_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (!active_q[k_q] || (gl_arr_q[k_q] == '0 && gr_arr_q[k_q] == '0) ||
            (pos_cur >= len_fix && (!loop_arr_q[k_q] || len_arr_q[k_q] == '0))) begin
          state_d = last_voice ? ST_FINL : ST_CHECK;
        end else if (pos_cur >= len_fix) begin
          state_d = ST_WRAP;
        end else begin
          state_d = ST_ADDR;
        end
      end
      ST_WRAP: state_d = ST_ADDR;
      ST_ADDR: state_d = ST_MOD;
      ST_MOD: begin
        if (mod_done) begin
          state_d = ST_RD1;
        end
      end
      ST_RD1:  state_d = wide_arr_q[k_q] ? ST_RD2 : ST_MULL;
      ST_RD2:  state_d = ST_MULL;
      ST_MULL: state_d = ST_MULR;
      ST_MULR: state_d = ST_ACCR;
      ST_ACCR: state_d = last_voice ? ST_FINL : ST_CHECK;
      ST_FINL: state_d = ST_FINR;
      ST_FINR: state_d = ST_SATR;
      ST_SATR: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      master_q    <= MASTER_RESET;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        master_q <= cfg_wdata_i;
      end
      if (in_acc && voice_ok && in_data_i.func == FUNC_START) begin
        active_q[wr_idx] <= 1'b1;
      end else if (in_acc && voice_ok && in_data_i.func == FUNC_STOP) begin
        active_q[wr_idx] <= 1'b0;
      end else if (state_q == ST_CHECK && pos_cur >= len_fix &&
                   (!loop_arr_q[k_q] || len_arr_q[k_q] == '0)) begin
        // a finished one-shot voice, or a looping one of zero length, drops out without adding to this frame
        active_q[k_q] <= 1'b0;
      end
      if (in_acc) begin
        k_q <= '0;
      end else if ((state_q == ST_CHECK && state_d == ST_CHECK) || state_q == ST_ACCR) begin
        k_q <= k_q + VIW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_data_i;
    end
    if (in_acc && voice_ok && in_data_i.func == FUNC_START) begin
      pos_arr_q[wr_idx]  <= '0;
      base_arr_q[wr_idx] <= in_data_i.address;
      len_arr_q[wr_idx]  <= in_data_i.sample_count;
      lpt_arr_q[wr_idx]  <= in_data_i.loop_start;
      loop_arr_q[wr_idx] <= in_data_i.looping;
      inc_arr_q[wr_idx]  <= in_data_i.step;
      wide_arr_q[wr_idx] <= in_data_i.sixteen_bit;
      gl_arr_q[wr_idx]   <= in_data_i.left_volume;
      gr_arr_q[wr_idx]   <= in_data_i.right_volume;
    end
    if (state_q == ST_ACCR) begin
      pos_arr_q[k_q] <= pos_q + 32'(inc_arr_q[k_q]);
    end
    if (in_acc && in_data_i.func == FUNC_MIX) begin
      acc_l_q <= '0;
      acc_r_q <= '0;
    end
    case (state_q)
      ST_CHECK: pos_q <= (pos_cur >= len_fix) ? (pos_cur - len_fix) : pos_cur;
      ST_WRAP:  pos_q <= pos_q + 32'({lpt_arr_q[k_q], {FRACTION_BITS{1'b0}}});
      ST_MOD:   addr_q <= mod_rem;
      ST_RD1: begin
        lo_q <= rdata_q;
        // unsigned 8-bit with offset 128, scaled by 256
        sample_q <= {~rdata_q[7], rdata_q[6:0], 8'h00};
      end
      ST_RD2:  sample_q <= {rdata_q, lo_q};
      ST_MULR: acc_l_q <= acc_l_q + ACC_W'(prod_q);
      ST_ACCR: acc_r_q <= acc_r_q + ACC_W'(prod_q);
      ST_FINR: res_l_q <= sat16(prod_q);
      ST_SATR: res_r_q <= sat16(prod_q);
      default: ;
    endcase
    if (out_load) begin
      out_q.left_out  <= res_l_q;
      out_q.right_out <= res_r_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[sv/mvrm_addr_mod.sv]
// sample memory address reducer: dividend modulo the memory size
// a mask for power-of-two sizes, otherwise one dividend bit per cycle; no dependencies
`default_nettype none

module mvrm_addr_mod #(
  parameter int unsigned DIVIDEND_W = 22,
  parameter int unsigned MODULUS    = 65536,
  parameter int unsigned RES_W      = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  output logic                  done_o,
  output logic [RES_W-1:0]      rem_o
);

  localparam bit IS_POW2 = (MODULUS & (MODULUS - 1)) == 0;

  logic             done_q;
  logic [RES_W-1:0] rem_q;

  assign done_o = done_q;
  assign rem_o  = rem_q;

  if (IS_POW2) begin : g_mask
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        rem_q <= RES_W'(dividend_i);
      end
    end
  end else begin : g_serial
    localparam int unsigned CW = $clog2(DIVIDEND_W + 1);
    localparam logic [RES_W:0] MOD_W = (RES_W + 1)'(MODULUS);

    logic                  busy_q;
    logic [CW-1:0]         cnt_q;
    logic [DIVIDEND_W-1:0] div_q;
    logic [RES_W:0]        trial;
    logic [RES_W-1:0]      rem_next;

    // restoring remainder, most significant dividend bit first
    assign trial    = {rem_q, div_q[DIVIDEND_W-1]};
    assign rem_next = (trial >= MOD_W) ? RES_W'(trial - MOD_W) : RES_W'(trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        done_q <= 1'b0;
        cnt_q  <= '0;
      end else if (start_i) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= CW'(DIVIDEND_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else begin
        done_q <= 1'b0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        div_q <= dividend_i;
        rem_q <= '0;
      end else if (busy_q) begin
        div_q <= div_q << 1;
        rem_q <= rem_next;
      end
    end
  end

endmodule

`default_nettype wire

[sv/mvrm_checker.sv]
// port-level checker for the voice mixer, attached to the top level by bind
// depends on mvrm_pkg
`default_nettype none

module mvrm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input mvrm_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input mvrm_pkg::out_item_t out_data_o,
  input logic                cfg_we_i,
  input logic [8:0]          cfg_wdata_i
);

  import mvrm_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // a pending frame holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("pending frame changed before it was taken");

  // start and stop finish in the cycle they are taken
  a_ctl_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.func == FUNC_START || in_data_i.func == FUNC_STOP)
    |=> in_ready_o)
    else $error("not ready after a start or stop request");

  // loads and mixes leave the block busy in the cycle after they are taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.func == FUNC_LOAD || in_data_i.func == FUNC_MIX)
    |=> !in_ready_o)
    else $error("ready directly after a load or mix request");

  // a new frame only appears at the end of a mix, as the block turns ready again
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o) && in_ready_o)
    else $error("frame appeared outside the end of a mix");

endmodule

bind multi_voice_resampling_mixer mvrm_checker u_mvrm_checker (.*);

`default_nettype wire
